### hw/rtl/psl_pkg.sv
// Shared types, constants and helper functions for the positional stereo level unit.
// No dependencies; every other file refers to this package by scoped names.
package psl_pkg;

    localparam int COORD_BITS    = 24;
    localparam int CORDIC_STAGES = 16;
    localparam int DIFF_W        = COORD_BITS + 1;
    localparam int RANGE_W       = 23;
    localparam int PAN_CFG_W     = 8;
    localparam int MAG_W         = (DIFF_W > RANGE_W) ? DIFF_W : RANGE_W;
    localparam int PSQ_W         = 2 * RANGE_W;
    localparam int SQ_W          = 2 * RANGE_W + 2;
    localparam int ROOT_W        = SQ_W / 2;
    localparam int SQRT_STEPS    = ROOT_W;
    localparam int STEP_W        = 5;
    localparam int PRESCALE      = 8;
    localparam int CX_W          = RANGE_W + PRESCALE + 5;
    localparam int ANG_W         = 16;
    localparam int COS_W         = 20;
    localparam int CZ_W          = 18;
    localparam int DIV_STEPS     = 8;
    localparam int REM_W         = RANGE_W + DIV_STEPS + 1;
    localparam int ROT_CELLS     = (CORDIC_STAGES > DIV_STEPS) ? CORDIC_STAGES : DIV_STEPS;
    localparam int NEAR_SCALE    = 100;
    localparam int COS_START     = 39797;
    localparam int ONE_Q16       = 65536;
    localparam int CQ_W          = 18;
    localparam int CM_W          = 19;
    localparam int PROD_W        = 28;
    localparam int PAN_W         = 11;
    localparam int SUM_W         = 12;
    localparam int LP_W          = 21;
    localparam int NEARV_W       = 7;
    localparam int VOL_W         = 7;
    localparam int CUE_W         = 16;
    localparam int CFG_IDX_W     = 3;

    localparam logic signed [CZ_W-1:0] QUARTER_TURN = 16384;
    localparam logic signed [CZ_W-1:0] HALF_TURN    = 32768;
    localparam logic [ANG_W-1:0]       HALF_TURN_U  = 16'h8000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AUDIBLE_RANGE = 3'd0,
        REG_NEAR_FIELD    = 3'd1,
        REG_PAN_DEAD_ZONE = 3'd2,
        REG_PAN_SWING     = 3'd3,
        REG_PAN_CENTRE    = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic [RANGE_W-1:0]   audible_range;
        logic [RANGE_W-1:0]   near_field;
        logic [RANGE_W-1:0]   pan_dead_zone;
        logic [PAN_CFG_W-1:0] pan_swing;
        logic [PAN_CFG_W-1:0] pan_centre;
    } cfg_t;

    typedef struct packed {
        logic [CUE_W-1:0]       cue;
        logic [ANG_W-1:0]       yaw;
        logic                   out;
        logic [SQ_W-1:0]        sq_rem;
        logic [SQ_W-1:0]        sq_root;
        logic [SQ_W-1:0]        fl_rem;
        logic [SQ_W-1:0]        fl_root;
        logic signed [CX_W-1:0] cx;
        logic signed [CX_W-1:0] cy;
        logic [ANG_W-1:0]       acc;
    } root_item_t;

    typedef struct packed {
        logic [CUE_W-1:0]        cue;
        logic                    out;
        logic [REM_W-1:0]        lv_rem;
        logic [DIV_STEPS-1:0]    lv_q;
        logic [REM_W-1:0]        nr_rem;
        logic [DIV_STEPS-1:0]    nr_q;
        logic                    near_ok;
        logic                    pan_on;
        logic                    neg;
        logic                    cneg;
        logic signed [COS_W-1:0] cx;
        logic signed [COS_W-1:0] cy;
        logic signed [CZ_W-1:0]  cz;
    } rot_item_t;

    function automatic logic [ANG_W-1:0] angle_tab(input logic [STEP_W-1:0] i);
        logic [ANG_W-1:0] a;
        unique case (i)
            5'd0:    a = 16'd8192;
            5'd1:    a = 16'd4836;
            5'd2:    a = 16'd2555;
            5'd3:    a = 16'd1297;
            5'd4:    a = 16'd651;
            5'd5:    a = 16'd326;
            5'd6:    a = 16'd163;
            5'd7:    a = 16'd81;
            5'd8:    a = 16'd41;
            5'd9:    a = 16'd20;
            5'd10:   a = 16'd10;
            5'd11:   a = 16'd5;
            5'd12:   a = 16'd3;
            5'd13:   a = 16'd1;
            5'd14:   a = 16'd1;
            default: a = 16'd0;
        endcase
        return a;
    endfunction

    function automatic rot_item_t rot_prep(input root_item_t a, input cfg_t c);
        logic [ROOT_W-1:0]      d;
        logic [ROOT_W-1:0]      flat;
        logic [ANG_W-1:0]       rel;
        logic [ANG_W-1:0]       phi;
        logic signed [CZ_W-1:0] z;
        rot_item_t              o;
        d         = a.sq_root[ROOT_W-1:0];
        flat      = a.fl_root[ROOT_W-1:0];
        o.cue     = a.cue;
        o.out     = a.out;
        o.lv_rem  = REM_W'(c.audible_range - d[RANGE_W-1:0]) << (DIV_STEPS - 1);
        o.lv_q    = '0;
        o.near_ok = (c.near_field != '0) && (flat < ROOT_W'(c.near_field));
        o.nr_rem  = o.near_ok ?
                    REM_W'(c.near_field - flat[RANGE_W-1:0]) * REM_W'(NEAR_SCALE) : '0;
        o.nr_q    = '0;
        o.pan_on  = flat > ROOT_W'(c.pan_dead_zone);
        rel       = a.acc - a.yaw;
        o.neg     = (rel != '0) && !rel[ANG_W-1];
        phi       = {rel[ANG_W-2:0], 1'b0};
        z         = CZ_W'($signed(phi));
        o.cneg    = 1'b0;
        if (z > QUARTER_TURN)
        begin
            z      = z - HALF_TURN;
            o.cneg = 1'b1;
        end
        else if (z < -QUARTER_TURN)
        begin
            z      = z + HALF_TURN;
            o.cneg = 1'b1;
        end
        o.cx = COS_W'(COS_START);
        o.cy = '0;
        o.cz = z;
        return o;
    endfunction

endpackage

### hw/rtl/psl_front.sv
// Front stages: coordinate differences, range screen, squares and bearing setup.
// Depends on psl_pkg.
module psl_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [psl_pkg::CUE_W-1:0]            cue_id,
    input  logic signed [psl_pkg::COORD_BITS-1:0] source_x,
    input  logic signed [psl_pkg::COORD_BITS-1:0] source_y,
    input  logic signed [psl_pkg::COORD_BITS-1:0] source_z,
    input  logic signed [psl_pkg::COORD_BITS-1:0] listener_x,
    input  logic signed [psl_pkg::COORD_BITS-1:0] listener_y,
    input  logic signed [psl_pkg::COORD_BITS-1:0] listener_z,
    input  logic [psl_pkg::ANG_W-1:0]            listener_yaw,
    input  logic [psl_pkg::RANGE_W-1:0]          audible_range,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output psl_pkg::root_item_t                  out_item
);

    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    logic [psl_pkg::CUE_W-1:0]               cue1_reg, cue2_reg;
    logic [psl_pkg::ANG_W-1:0]               yaw1_reg, yaw2_reg;
    logic signed [psl_pkg::DIFF_W-1:0]       dx1_reg, dy1_reg, dx2_reg, dy2_reg;
    logic [psl_pkg::MAG_W-1:0]               ax1_reg, ay1_reg, az1_reg;
    logic                                    out1_reg, out2_reg;
    logic [psl_pkg::PSQ_W-1:0]               sqx2_reg, sqy2_reg, sqz2_reg, rr2_reg;
    psl_pkg::root_item_t                     item3_reg;

    logic signed [psl_pkg::DIFF_W-1:0]       dx_next, dy_next, dz_next;
    logic [psl_pkg::MAG_W-1:0]               ax_next, ay_next, az_next;
    logic                                    out1_next;
    logic [psl_pkg::RANGE_W-1:0]             mx, my, mz;
    logic [psl_pkg::SQ_W-1:0]                flatsq, sum;
    logic signed [psl_pkg::CX_W-1:0]         x0, y0;
    psl_pkg::root_item_t                     item3_next;

    assign rdy3      = !v3_reg || out_ready;
    assign rdy2      = !v2_reg || rdy3;
    assign rdy1      = !v1_reg || rdy2;
    assign in_ready  = rdy1;
    assign out_valid = v3_reg;
    assign out_item  = item3_reg;

    always_comb
    begin
        dx_next   = psl_pkg::DIFF_W'(source_x) - psl_pkg::DIFF_W'(listener_x);
        dy_next   = psl_pkg::DIFF_W'(source_y) - psl_pkg::DIFF_W'(listener_y);
        dz_next   = psl_pkg::DIFF_W'(source_z) - psl_pkg::DIFF_W'(listener_z);
        ax_next   = psl_pkg::MAG_W'(dx_next[psl_pkg::DIFF_W-1] ? -dx_next : dx_next);
        ay_next   = psl_pkg::MAG_W'(dy_next[psl_pkg::DIFF_W-1] ? -dy_next : dy_next);
        az_next   = psl_pkg::MAG_W'(dz_next[psl_pkg::DIFF_W-1] ? -dz_next : dz_next);
        out1_next = (ax_next >= psl_pkg::MAG_W'(audible_range))
                 || (ay_next >= psl_pkg::MAG_W'(audible_range))
                 || (az_next >= psl_pkg::MAG_W'(audible_range));
        mx        = ax1_reg[psl_pkg::RANGE_W-1:0];
        my        = ay1_reg[psl_pkg::RANGE_W-1:0];
        mz        = az1_reg[psl_pkg::RANGE_W-1:0];
    end

    always_comb
    begin
        flatsq = psl_pkg::SQ_W'(sqx2_reg) + psl_pkg::SQ_W'(sqy2_reg);
        sum    = flatsq + psl_pkg::SQ_W'(sqz2_reg);
        x0     = psl_pkg::CX_W'(dx2_reg) <<< psl_pkg::PRESCALE;
        y0     = psl_pkg::CX_W'(dy2_reg) <<< psl_pkg::PRESCALE;
        item3_next.cue     = cue2_reg;
        item3_next.yaw     = yaw2_reg;
        item3_next.out     = out2_reg || (sum >= psl_pkg::SQ_W'(rr2_reg));
        item3_next.sq_rem  = sum;
        item3_next.sq_root = '0;
        item3_next.fl_rem  = flatsq;
        item3_next.fl_root = '0;
        if (dx2_reg[psl_pkg::DIFF_W-1])
        begin
            item3_next.cx  = -x0;
            item3_next.cy  = -y0;
            item3_next.acc = psl_pkg::HALF_TURN_U;
        end
        else
        begin
            item3_next.cx  = x0;
            item3_next.cy  = y0;
            item3_next.acc = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && rdy1)
        begin
            cue1_reg <= cue_id;
            yaw1_reg <= listener_yaw;
            dx1_reg  <= dx_next;
            dy1_reg  <= dy_next;
            ax1_reg  <= ax_next;
            ay1_reg  <= ay_next;
            az1_reg  <= az_next;
            out1_reg <= out1_next;
        end
        if (v1_reg && rdy2)
        begin
            cue2_reg <= cue1_reg;
            yaw2_reg <= yaw1_reg;
            dx2_reg  <= dx1_reg;
            dy2_reg  <= dy1_reg;
            out2_reg <= out1_reg;
            sqx2_reg <= psl_pkg::PSQ_W'(mx) * psl_pkg::PSQ_W'(mx);
            sqy2_reg <= psl_pkg::PSQ_W'(my) * psl_pkg::PSQ_W'(my);
            sqz2_reg <= psl_pkg::PSQ_W'(mz) * psl_pkg::PSQ_W'(mz);
            rr2_reg  <= psl_pkg::PSQ_W'(audible_range) * psl_pkg::PSQ_W'(audible_range);
        end
        if (v2_reg && rdy3)
        begin
            item3_reg <= item3_next;
        end
    end

endmodule

### hw/rtl/psl_root_cell.sv
// One cell of the root chain: a square-root digit for 3D and flat distance
// and a bearing CORDIC rotation if step < CORDIC_STAGES. Depends on psl_pkg.
module psl_root_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [psl_pkg::STEP_W-1:0]  step,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  psl_pkg::root_item_t         in_item,
    output logic                        out_valid,
    input  logic                        out_ready,
    output psl_pkg::root_item_t         out_item
);

    logic                            valid_reg;
    psl_pkg::root_item_t             item_reg;
    psl_pkg::root_item_t             item_next;
    logic [psl_pkg::STEP_W-1:0]      k;
    logic [psl_pkg::SQ_W-1:0]        b, t_sq, t_fl;
    logic signed [psl_pkg::CX_W-1:0] x, y;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        item_next = in_item;
        k         = psl_pkg::STEP_W'(psl_pkg::SQRT_STEPS - 1) - step;
        b         = psl_pkg::SQ_W'(1) << {k, 1'b0};
        t_sq      = in_item.sq_root + b;
        t_fl      = in_item.fl_root + b;
        if (in_item.sq_rem >= t_sq)
        begin
            item_next.sq_rem  = in_item.sq_rem - t_sq;
            item_next.sq_root = (in_item.sq_root >> 1) + b;
        end
        else
        begin
            item_next.sq_root = in_item.sq_root >> 1;
        end
        if (in_item.fl_rem >= t_fl)
        begin
            item_next.fl_rem  = in_item.fl_rem - t_fl;
            item_next.fl_root = (in_item.fl_root >> 1) + b;
        end
        else
        begin
            item_next.fl_root = in_item.fl_root >> 1;
        end
        x = in_item.cx;
        y = in_item.cy;
        if (step < psl_pkg::STEP_W'(psl_pkg::CORDIC_STAGES))
        begin
            if (y[psl_pkg::CX_W-1])
            begin
                item_next.cx  = x - (y >>> step);
                item_next.cy  = y + (x >>> step);
                item_next.acc = in_item.acc - psl_pkg::angle_tab(step);
            end
            else
            begin
                item_next.cx  = x + (y >>> step);
                item_next.cy  = y - (x >>> step);
                item_next.acc = in_item.acc + psl_pkg::angle_tab(step);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

### hw/rtl/psl_rot_cell.sv
// One cell of the level chain: a quotient bit for level and near-field floor
// if step < DIV_STEPS and one cosine CORDIC rotation. Depends on psl_pkg.
module psl_rot_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [psl_pkg::STEP_W-1:0]   step,
    input  logic [psl_pkg::RANGE_W-1:0]  audible_range,
    input  logic [psl_pkg::RANGE_W-1:0]  near_field,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  psl_pkg::rot_item_t           in_item,
    output logic                         out_valid,
    input  logic                         out_ready,
    output psl_pkg::rot_item_t           out_item
);

    logic                             valid_reg;
    psl_pkg::rot_item_t               item_reg;
    psl_pkg::rot_item_t               item_next;
    logic [psl_pkg::STEP_W-1:0]       sh;
    logic [psl_pkg::REM_W-1:0]        dv_lv, dv_nr;
    logic [psl_pkg::DIV_STEPS-1:0]    qbit;
    logic signed [psl_pkg::COS_W-1:0] x, y;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        item_next = in_item;
        sh        = psl_pkg::STEP_W'(psl_pkg::DIV_STEPS - 1) - step;
        dv_lv     = psl_pkg::REM_W'(audible_range) << sh;
        dv_nr     = psl_pkg::REM_W'(near_field) << sh;
        qbit      = psl_pkg::DIV_STEPS'(1) << sh;
        if (step < psl_pkg::STEP_W'(psl_pkg::DIV_STEPS))
        begin
            if (in_item.lv_rem >= dv_lv)
            begin
                item_next.lv_rem = in_item.lv_rem - dv_lv;
                item_next.lv_q   = in_item.lv_q | qbit;
            end
            if (in_item.nr_rem >= dv_nr)
            begin
                item_next.nr_rem = in_item.nr_rem - dv_nr;
                item_next.nr_q   = in_item.nr_q | qbit;
            end
        end
        x = in_item.cx;
        y = in_item.cy;
        if (step < psl_pkg::STEP_W'(psl_pkg::CORDIC_STAGES))
        begin
            if (!in_item.cz[psl_pkg::CZ_W-1])
            begin
                item_next.cx = x - (y >>> step);
                item_next.cy = y + (x >>> step);
                item_next.cz = in_item.cz - psl_pkg::CZ_W'(psl_pkg::angle_tab(step));
            end
            else
            begin
                item_next.cx = x + (y >>> step);
                item_next.cy = y - (x >>> step);
                item_next.cz = in_item.cz + psl_pkg::CZ_W'(psl_pkg::angle_tab(step));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

### hw/rtl/psl_back.sv
// Back stages: pan term, left and right scaling, near-field floor and clamp.
// Depends on psl_pkg.
module psl_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  psl_pkg::rot_item_t             in_item,
    input  logic [psl_pkg::PAN_CFG_W-1:0]  pan_swing,
    input  logic [psl_pkg::PAN_CFG_W-1:0]  pan_centre,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [psl_pkg::CUE_W-1:0]      cue_out,
    output logic                           in_range,
    output logic [psl_pkg::VOL_W-1:0]      volume_left,
    output logic [psl_pkg::VOL_W-1:0]      volume_right
);

    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    logic [psl_pkg::CUE_W-1:0]          cue1_reg, cue2_reg, cue3_reg;
    logic                               out1_reg, out2_reg, out3_reg;
    logic signed [psl_pkg::PROD_W-1:0]  prod1_reg;
    logic [psl_pkg::DIV_STEPS-1:0]      level1_reg;
    logic [psl_pkg::NEARV_W-1:0]        nearv1_reg, nearv2_reg;
    logic                               pan_on1_reg, neg1_reg;
    logic signed [psl_pkg::LP_W-1:0]    lp2_reg, rp2_reg;
    logic [psl_pkg::VOL_W-1:0]          vl3_reg, vr3_reg;

    logic signed [psl_pkg::COS_W:0]     xn;
    logic signed [psl_pkg::CQ_W-1:0]    cq;
    logic signed [psl_pkg::CM_W-1:0]    cm;
    logic signed [psl_pkg::PROD_W-1:0]  prod_next;
    logic [psl_pkg::DIV_STEPS-1:0]      nmin;
    logic [psl_pkg::NEARV_W-1:0]        nearv_next;
    logic signed [psl_pkg::PROD_W-1:0]  pos;
    logic signed [psl_pkg::PAN_W-1:0]   pm, pan;
    logic signed [psl_pkg::SUM_W-1:0]   lsum, rsum;
    logic signed [psl_pkg::LP_W-1:0]    lp_next, rp_next, lvl_s;
    logic signed [psl_pkg::LP_W-1:0]    lside, rside, nv;
    logic [psl_pkg::VOL_W-1:0]          vl_next, vr_next;

    assign rdy3         = !v3_reg || out_ready;
    assign rdy2         = !v2_reg || rdy3;
    assign rdy1         = !v1_reg || rdy2;
    assign in_ready     = rdy1;
    assign out_valid    = v3_reg;
    assign cue_out      = cue3_reg;
    assign in_range     = !out3_reg;
    assign volume_left  = vl3_reg;
    assign volume_right = vr3_reg;

    always_comb
    begin
        xn = in_item.cneg ? -(psl_pkg::COS_W + 1)'(in_item.cx)
                          : (psl_pkg::COS_W + 1)'(in_item.cx);
        if (xn > (psl_pkg::COS_W + 1)'(psl_pkg::ONE_Q16))
        begin
            cq = psl_pkg::CQ_W'(psl_pkg::ONE_Q16);
        end
        else if (xn < -(psl_pkg::COS_W + 1)'(psl_pkg::ONE_Q16))
        begin
            cq = -psl_pkg::CQ_W'(psl_pkg::ONE_Q16);
        end
        else
        begin
            cq = psl_pkg::CQ_W'(xn);
        end
        cm        = psl_pkg::CM_W'(cq) - psl_pkg::CM_W'(psl_pkg::ONE_Q16);
        prod_next = psl_pkg::PROD_W'(cm) * psl_pkg::PROD_W'($signed({1'b0, pan_swing}));
        nmin      = (in_item.nr_q < in_item.lv_q) ? in_item.nr_q : in_item.lv_q;
        nearv_next = in_item.near_ok ? psl_pkg::NEARV_W'(nmin) : '0;
    end

    always_comb
    begin
        pos     = -prod1_reg;
        pm      = psl_pkg::PAN_W'(pos >> 16);
        if (!pan_on1_reg)
        begin
            pan = '0;
        end
        else if (neg1_reg)
        begin
            pan = pm;
        end
        else
        begin
            pan = -pm;
        end
        lsum    = psl_pkg::SUM_W'($signed({1'b0, pan_centre})) + psl_pkg::SUM_W'(pan);
        rsum    = psl_pkg::SUM_W'($signed({1'b0, pan_centre})) - psl_pkg::SUM_W'(pan);
        lvl_s   = psl_pkg::LP_W'($signed({1'b0, level1_reg}));
        lp_next = psl_pkg::LP_W'(lsum) * lvl_s;
        rp_next = psl_pkg::LP_W'(rsum) * lvl_s;
    end

    always_comb
    begin
        lside = lp2_reg[psl_pkg::LP_W-1] ? -((-lp2_reg) >>> 7) : (lp2_reg >>> 7);
        rside = rp2_reg[psl_pkg::LP_W-1] ? -((-rp2_reg) >>> 7) : (rp2_reg >>> 7);
        nv    = psl_pkg::LP_W'($signed({1'b0, nearv2_reg}));
        if (nv <= lside)
        begin
            vl_next = (lside > psl_pkg::LP_W'(127)) ? psl_pkg::VOL_W'(127)
                                                     : lside[psl_pkg::VOL_W-1:0];
        end
        else
        begin
            vl_next = nearv2_reg;
        end
        if (nv <= rside)
        begin
            vr_next = (rside > psl_pkg::LP_W'(127)) ? psl_pkg::VOL_W'(127)
                                                     : rside[psl_pkg::VOL_W-1:0];
        end
        else
        begin
            vr_next = nearv2_reg;
        end
        if (out2_reg)
        begin
            vl_next = '0;
            vr_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && rdy1)
        begin
            cue1_reg    <= in_item.cue;
            out1_reg    <= in_item.out;
            prod1_reg   <= prod_next;
            level1_reg  <= in_item.lv_q;
            nearv1_reg  <= nearv_next;
            pan_on1_reg <= in_item.pan_on;
            neg1_reg    <= in_item.neg;
        end
        if (v1_reg && rdy2)
        begin
            cue2_reg   <= cue1_reg;
            out2_reg   <= out1_reg;
            nearv2_reg <= nearv1_reg;
            lp2_reg    <= lp_next;
            rp2_reg    <= rp_next;
        end
        if (v2_reg && rdy3)
        begin
            cue3_reg <= cue2_reg;
            out3_reg <= out2_reg;
            vl3_reg  <= vl_next;
            vr3_reg  <= vr_next;
        end
    end

endmodule

### hw/rtl/positional_stereo_level_unit.sv
// Top level of the positional stereo level unit: configuration registers and the cell chains.
// Depends on psl_pkg, psl_front, psl_root_cell, psl_rot_cell and psl_back.
//
// Takes one request per clock unless stalled and returns left and right volumes in order: 3
// front stages (differences, squares, sums), 24 root cells (one square-root digit each, a
// bearing rotation in the first 16), 16 level cells (a cosine rotation each, a quotient bit in
// the first 8) and 3 back stages (pan, scaling, clamp). Each cell has its own valid bit and
// moves forward whenever the cell after it is empty or moving, so bubbles close up and a
// stalled output fills the chain before in_ready falls. Write configuration only when idle.
module positional_stereo_level_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [psl_pkg::CUE_W-1:0]             cue_id,
    input  logic signed [psl_pkg::COORD_BITS-1:0] source_x,
    input  logic signed [psl_pkg::COORD_BITS-1:0] source_y,
    input  logic signed [psl_pkg::COORD_BITS-1:0] source_z,
    input  logic signed [psl_pkg::COORD_BITS-1:0] listener_x,
    input  logic signed [psl_pkg::COORD_BITS-1:0] listener_y,
    input  logic signed [psl_pkg::COORD_BITS-1:0] listener_z,
    input  logic [psl_pkg::ANG_W-1:0]             listener_yaw,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [psl_pkg::CUE_W-1:0]             cue_out,
    output logic                                  in_range,
    output logic [psl_pkg::VOL_W-1:0]             volume_left,
    output logic [psl_pkg::VOL_W-1:0]             volume_right,
    input  logic                                  cfg_we,
    input  logic [psl_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [psl_pkg::RANGE_W-1:0]           cfg_wdata
);

    psl_pkg::cfg_t cfg_reg;

    logic                rv [psl_pkg::SQRT_STEPS+1];
    logic                rr [psl_pkg::SQRT_STEPS+1];
    psl_pkg::root_item_t ri [psl_pkg::SQRT_STEPS+1];
    logic                qv [psl_pkg::ROT_CELLS+1];
    logic                qr [psl_pkg::ROT_CELLS+1];
    psl_pkg::rot_item_t  qi [psl_pkg::ROT_CELLS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.audible_range <= psl_pkg::RANGE_W'(65536);
            cfg_reg.near_field    <= psl_pkg::RANGE_W'(16384);
            cfg_reg.pan_dead_zone <= psl_pkg::RANGE_W'(256);
            cfg_reg.pan_swing     <= psl_pkg::PAN_CFG_W'(64);
            cfg_reg.pan_centre    <= psl_pkg::PAN_CFG_W'(64);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                psl_pkg::REG_AUDIBLE_RANGE: cfg_reg.audible_range <= cfg_wdata;
                psl_pkg::REG_NEAR_FIELD:    cfg_reg.near_field    <= cfg_wdata;
                psl_pkg::REG_PAN_DEAD_ZONE: cfg_reg.pan_dead_zone <= cfg_wdata;
                psl_pkg::REG_PAN_SWING:
                    cfg_reg.pan_swing  <= cfg_wdata[psl_pkg::PAN_CFG_W-1:0];
                psl_pkg::REG_PAN_CENTRE:
                    cfg_reg.pan_centre <= cfg_wdata[psl_pkg::PAN_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    psl_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cue_id        (cue_id),
        .source_x      (source_x),
        .source_y      (source_y),
        .source_z      (source_z),
        .listener_x    (listener_x),
        .listener_y    (listener_y),
        .listener_z    (listener_z),
        .listener_yaw  (listener_yaw),
        .audible_range (cfg_reg.audible_range),
        .out_valid     (rv[0]),
        .out_ready     (rr[0]),
        .out_item      (ri[0])
    );

    for (genvar g = 0; g < psl_pkg::SQRT_STEPS; g++)
    begin : g_root
        psl_root_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .step      (psl_pkg::STEP_W'(g)),
            .in_valid  (rv[g]),
            .in_ready  (rr[g]),
            .in_item   (ri[g]),
            .out_valid (rv[g+1]),
            .out_ready (rr[g+1]),
            .out_item  (ri[g+1])
        );
    end

    assign qv[0]                    = rv[psl_pkg::SQRT_STEPS];
    assign rr[psl_pkg::SQRT_STEPS]  = qr[0];
    assign qi[0]                    = psl_pkg::rot_prep(ri[psl_pkg::SQRT_STEPS], cfg_reg);

    for (genvar g = 0; g < psl_pkg::ROT_CELLS; g++)
    begin : g_rot
        psl_rot_cell u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .step          (psl_pkg::STEP_W'(g)),
            .audible_range (cfg_reg.audible_range),
            .near_field    (cfg_reg.near_field),
            .in_valid      (qv[g]),
            .in_ready      (qr[g]),
            .in_item       (qi[g]),
            .out_valid     (qv[g+1]),
            .out_ready     (qr[g+1]),
            .out_item      (qi[g+1])
        );
    end

    psl_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (qv[psl_pkg::ROT_CELLS]),
        .in_ready     (qr[psl_pkg::ROT_CELLS]),
        .in_item      (qi[psl_pkg::ROT_CELLS]),
        .pan_swing    (cfg_reg.pan_swing),
        .pan_centre   (cfg_reg.pan_centre),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .cue_out      (cue_out),
        .in_range     (in_range),
        .volume_left  (volume_left),
        .volume_right (volume_right)
    );

endmodule

### hw/rtl/psl_checker.sv
// Port-level checks for the positional stereo level unit, bound to the top level.
// Depends on psl_pkg and positional_stereo_level_unit.
module psl_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [psl_pkg::CUE_W-1:0] cue_out,
    input logic                      in_range,
    input logic [psl_pkg::VOL_W-1:0] volume_left,
    input logic [psl_pkg::VOL_W-1:0] volume_right
);

    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result shown during reset");

    a_silent_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !in_range |-> volume_left == '0 && volume_right == '0)
        else $error("out-of-range request has nonzero volume");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before accept");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(cue_out) && $stable(in_range)
            && $stable(volume_left) && $stable(volume_right))
        else $error("stalled result changed");

endmodule

bind positional_stereo_level_unit psl_checker u_psl_checker (.*);
